/* rtl/impact_detector_ema_hold_macros.svh */
// Assertion macros used by the impact detector datapath
`ifndef IMPACT_DETECTOR_EMA_HOLD_MACROS_SVH
`define IMPACT_DETECTOR_EMA_HOLD_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define IDEH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset
`define IDEH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ideh_pkg.sv */
// Types and constants for the impact detector
package ideh_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 7;
  localparam int ACC_W     = 24;
  localparam int SUM_W     = 32;
  localparam int MAG_W     = 16;
  localparam int ALPHA_W   = 17;
  localparam int THR_W     = 16;
  localparam int HOLD_W    = 16;
  localparam int TIME_W    = 32;
  localparam int DELTA_W   = 17;
  localparam int CNT_W     = 4;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int AXES      = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_HOLD  = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_MUL,
    ST_UPD
  } ideh_state_t;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       root_en;
    logic       mul_en;
    logic       commit;
  } ideh_cmd_t;

  typedef struct packed {
    logic out_free;
    logic out_valid;
  } ideh_sts_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [THR_W-1:0]   thr;
    logic [HOLD_W-1:0]  hold;
  } ideh_cfg_t;

endpackage

/* rtl/ideh_regs.sv */
// Configuration register file behind the APB-style port
module ideh_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ideh_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ideh_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ideh_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output ideh_pkg::ideh_cfg_t               cfg
);
  import ideh_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic [THR_W-1:0]   thr_r;
  logic [HOLD_W-1:0]  hold_r;
  logic [1:0]         idx;
  logic               wr;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_W'(6554);
      thr_r   <= THR_W'(1920);
      hold_r  <= HOLD_W'(3000);
    end else if (wr) begin
      unique case (idx)
        REG_ALPHA: alpha_r <= cfg_pwdata[ALPHA_W-1:0];
        REG_THR:   thr_r   <= cfg_pwdata[THR_W-1:0];
        REG_HOLD:  hold_r  <= cfg_pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALPHA: cfg_prdata = CFG_DATA_W'(alpha_r);
      REG_THR:   cfg_prdata = CFG_DATA_W'(thr_r);
      REG_HOLD:  cfg_prdata = CFG_DATA_W'(hold_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.alpha = alpha_r;
  assign cfg.thr   = thr_r;
  assign cfg.hold  = hold_r;

endmodule

/* rtl/ideh_ctrl.sv */
// Sequencer: square, root, EMA multiply and commit phases
module ideh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ideh_pkg::ideh_sts_t  sts,
  output ideh_pkg::ideh_cmd_t  cmd
);
  import ideh_pkg::*;

  ideh_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (cnt_r == CNT_W'(AXES - 1)) begin
          state_nxt = ST_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_UPD;
      ST_UPD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SQ: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = cnt_r[1:0];
      end
      ST_ROOT: cmd.root_en = 1'b1;
      ST_MUL:  cmd.mul_en  = 1'b1;
      ST_UPD:  cmd.commit  = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/ideh_dpath.sv */
// Datapath: sum of squares, bit-serial root, EMA update, alarm, result register
`include "impact_detector_ema_hold_macros.svh"
module ideh_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ideh_pkg::ideh_cmd_t                cmd,
  output ideh_pkg::ideh_sts_t                sts,
  input  ideh_pkg::ideh_cfg_t                cfg,
  input  logic [ideh_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ideh_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ideh_pkg::*;

  logic signed [SAMPLE_W-1:0] x_r, y_r, z_r;
  logic [TIME_W-1:0]          now_r;

  logic [SUM_W-1:0]           n_r, n_nxt;
  logic [SUM_W-1:0]           res_r, res_nxt;
  logic [SUM_W-1:0]           bit_r, bit_nxt;

  logic [ACC_W-1:0]           base_r;
  logic                       alarm_r;
  logic [TIME_W-1:0]          trig_r;

  logic signed [ACC_W+ALPHA_W+1:0] prod_r;

  logic [MAG_W-1:0]           mag_o_r;
  logic [MAG_W-1:0]           base_o_r;
  logic [DELTA_W-1:0]         delta_o_r;
  logic                       alarm_o_r, impact_o_r, release_o_r;
  logic                       out_valid_r;

  logic signed [SAMPLE_W-1:0]   axis;
  logic signed [2*SAMPLE_W-1:0] sq;
  logic [SUM_W:0]               trial;
  logic [MAG_W-1:0]             mag;
  logic signed [ACC_W:0]        magf, diff, fine, thrf;
  logic [ALPHA_W-1:0]           alpha_sat;
  logic signed [ALPHA_W:0]      alpha_s;
  logic [ACC_W-1:0]             base_new;
  logic [ACC_W-FRAC_W-1:0]      base_int;
  logic                         trig, alarm_mid, rel;
  logic [TIME_W-1:0]            trig_mid, elapsed;

  always_comb begin
    unique case (cmd.sq_sel)
      AXIS_X:  axis = x_r;
      AXIS_Y:  axis = y_r;
      default: axis = z_r;
    endcase
  end

  assign sq    = axis * axis;
  assign trial = {1'b0, res_r} + {1'b0, bit_r};

  always_comb begin
    n_nxt   = n_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (cmd.load) begin
      n_nxt   = '0;
      res_nxt = '0;
      bit_nxt = SUM_W'(1) << (SUM_W - 2);
    end else if (cmd.sq_en) begin
      n_nxt = n_r + SUM_W'(unsigned'(sq));
    end else if (cmd.root_en) begin
      bit_nxt = bit_r >> 2;
      if ({1'b0, n_r} >= trial) begin
        n_nxt   = n_r - trial[SUM_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
    end
  end

  assign mag       = res_r[MAG_W-1:0];
  assign magf      = signed'({2'b00, mag, FRAC_W'(0)});
  assign diff      = magf - signed'({1'b0, base_r});
  assign alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign alpha_s   = signed'({1'b0, alpha_sat});

  // floor(prod / 2^16) is the arithmetic shift
  assign base_new  = base_r + prod_r[ACC_W+15:16];
  assign fine      = magf - signed'({1'b0, base_new});
  assign thrf      = signed'({2'b00, cfg.thr, FRAC_W'(0)});
  assign base_int  = base_new[ACC_W-1:FRAC_W];

  assign trig      = (fine > thrf) && !alarm_r;
  assign alarm_mid = alarm_r | trig;
  assign trig_mid  = trig ? now_r : trig_r;
  assign elapsed   = now_r - trig_mid;
  assign rel       = alarm_mid && (elapsed > TIME_W'(cfg.hold));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_tdata[SAMPLE_W-1:0];
      y_r   <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      z_r   <= in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      now_r <= in_tdata[3*SAMPLE_W+TIME_W-1:3*SAMPLE_W];
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (cmd.mul_en) prod_r <= diff * alpha_s;
    if (cmd.commit) begin
      mag_o_r     <= mag;
      base_o_r    <= base_int[MAG_W-1:0];
      delta_o_r   <= DELTA_W'({1'b0, mag} - base_int);
      alarm_o_r   <= alarm_mid & ~rel;
      impact_o_r  <= trig;
      release_o_r <= rel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      alarm_r     <= 1'b0;
      trig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        base_r  <= base_new;
        alarm_r <= alarm_mid & ~rel;
        trig_r  <= trig_mid;
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free  = ~out_valid_r | out_tready;
  assign sts.out_valid = out_valid_r;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {4'b0, release_o_r, impact_o_r, alarm_o_r,
                          delta_o_r, base_o_r, mag_o_r};

  `IDEH_ASSERT_NOW(a_pulse_excl, out_valid_r, !(impact_o_r && release_o_r), "impact and release on one beat")
  `IDEH_ASSERT_NOW(a_impact_on, out_valid_r && impact_o_r, alarm_o_r, "impact beat without alarm")
  `IDEH_ASSERT_NOW(a_release_off, out_valid_r && release_o_r, !alarm_o_r, "release beat with alarm")
  `IDEH_ASSERT_NOW(a_root_narrow, cmd.commit, res_r[SUM_W-1:MAG_W] == '0, "root exceeds magnitude width")
  `IDEH_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_r && (alarm_r == alarm_o_r), "result register not loaded")

endmodule

/* rtl/impact_detector_ema_hold.sv */
// Top level of the impact detector with EMA baseline and alarm hold
//
//   port group | dir | beat contents
//   in_        | in  | accel_x, accel_y, accel_z, now_ms
//   out_       | out | magnitude, baseline, delta, alarm_on, impact_pulse, release_pulse
//   cfg_       | in  | alpha_q16 @0x0, impact_threshold @0x4, hold_ms @0x8
//
// Per sample: accept, axis squares on the shared squaring multiplier, the bit-serial
// square root, one EMA multiply, one update/commit; new samples are taken only in idle.
// The result register frees the input side: the next sample is taken while a
// result waits on out_tready; a commit stalls only while that register is full.
// rst_n is synchronous; it clears baseline, alarm, trigger time and output valid.
module impact_detector_ema_hold (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
  input  logic [ideh_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // magnitude[15:0], baseline[31:16], delta[48:32], alarm_on[49],
  // impact_pulse[50], release_pulse[51], zero[55:52]
  output logic [ideh_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ideh_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ideh_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ideh_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import ideh_pkg::*;

  ideh_cfg_t cfg;
  ideh_cmd_t cmd;
  ideh_sts_t sts;

  ideh_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ideh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ideh_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* verif/tb_impact_detector_ema_hold.sv */
// Self-checking testbench for the impact detector: sample stream in, checked readings out
`timescale 1ns / 1ps

module tb_impact_detector_ema_hold;
  import ideh_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [MAG_W-1:0]   baseline;
    logic [DELTA_W-1:0] delta;
    logic               alarm_on;
    logic               impact_pulse;
    logic               release_pulse;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // magnitude[15:0], baseline[31:16], delta[48:32], alarm_on[49],
  // impact_pulse[50], release_pulse[51], zero[55:52]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  impact_detector_ema_hold uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // detector shadow: configuration and state
  logic [ALPHA_W-1:0] alpha_reg = 17'd6554;
  logic [THR_W-1:0]   thr_reg = 16'd1920;
  logic [HOLD_W-1:0]  hold_reg = 16'd3000;
  logic [ACC_W-1:0]   base_acc = '0;
  logic               alarm_latched = 1'b0;
  logic [TIME_W-1:0]  trig_ms = '0;

  logic [IN_DATA_W-1:0] pending_samples[$];
  reading_t expected_readings[$];
  reading_t want;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_off_req = 0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  logic in_taken = 1'b0;

  function automatic void push_sample(int x, int y, int z, logic [31:0] stamp);
    pending_samples.push_back({stamp, 16'(z), 16'(y), 16'(x)});
  endfunction

  // one detector update: magnitude, EMA baseline, alarm latch/release
  function automatic reading_t detect_step(logic [IN_DATA_W-1:0] beat);
    longint sx, sy, sz, sq, trial, magf, diff, prod, fine;
    logic [15:0] root;
    logic [ALPHA_W-1:0] a;
    logic [31:0] stamp;
    logic [31:0] elapsed;
    reading_t r;
    sx = $signed(beat[15:0]);
    sy = $signed(beat[31:16]);
    sz = $signed(beat[47:32]);
    stamp = beat[79:48];
    sq = sx * sx + sy * sy + sz * sz;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (trial * trial <= sq) root[b] = 1'b1;
    end
    a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    magf = longint'(root) << FRAC_W;
    diff = magf - longint'(base_acc);
    prod = diff * longint'(a);
    base_acc = base_acc + ACC_W'(prod >>> 16);
    fine = magf - longint'(base_acc);
    r.impact_pulse = 1'b0;
    r.release_pulse = 1'b0;
    if (fine > (longint'(thr_reg) << FRAC_W) && !alarm_latched) begin
      alarm_latched = 1'b1;
      trig_ms = stamp;
      r.impact_pulse = 1'b1;
    end
    elapsed = stamp - trig_ms;
    if (alarm_latched && elapsed > {16'd0, hold_reg}) begin
      alarm_latched = 1'b0;
      r.release_pulse = 1'b1;
    end
    r.magnitude = root;
    r.baseline = 16'(base_acc >> FRAC_W);
    r.delta = DELTA_W'(longint'(root) - longint'(base_acc >> FRAC_W));
    r.alarm_on = alarm_latched;
    return r;
  endfunction

  function automatic void report_miss(string what, longint exp_val, longint got_val);
    if (mismatches < 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    mismatches++;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ALPHA: alpha_reg = value[ALPHA_W-1:0];
      REG_THR:   thr_reg = value[THR_W-1:0];
      REG_HOLD:  hold_reg = value[HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // wait until every sample is sent and every reading checked, then pause before going on
  task automatic settle();
    while (pending_samples.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= pending_samples.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // reading sink, with random stalls and a one-off long hold-off
  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) expected_readings.push_back(detect_step(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          report_miss("beat with nothing pending", 0, longint'(out_tdata));
        end else begin
          want = expected_readings.pop_front();
          if (out_tdata[15:0] !== want.magnitude)
            report_miss("magnitude", want.magnitude, out_tdata[15:0]);
          if (out_tdata[31:16] !== want.baseline)
            report_miss("baseline", want.baseline, out_tdata[31:16]);
          if (out_tdata[48:32] !== want.delta)
            report_miss("delta", longint'($signed(want.delta)),
                        longint'($signed(out_tdata[48:32])));
          if (out_tdata[49] !== want.alarm_on)
            report_miss("alarm_on", want.alarm_on, out_tdata[49]);
          if (out_tdata[50] !== want.impact_pulse)
            report_miss("impact_pulse", want.impact_pulse, out_tdata[50]);
          if (out_tdata[51] !== want.release_pulse)
            report_miss("release_pulse", want.release_pulse, out_tdata[51]);
        end
      end
      quiet_cycles = (in_taken || (out_tvalid && out_tready)) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[impact_detector_ema_hold] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int send_plan[4] = '{0, 57, 0, 17};
    int stall_plan[4] = '{0, 0, 57, 17};
    logic [31:0] clock_ms;
    int kind;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, trigger near the top of time, release after wrap
    push_sample(0, 0, 0, 32'd0);
    push_sample(-32768, -32768, -32768, 32'hFFFF_FF00);
    push_sample(32767, 32767, 32767, 32'h0000_0000);
    push_sample(-32768, 32767, 0, 32'h0000_0C00);
    push_sample(1, -1, 1, 32'h0000_0C10);
    settle();

    // frozen baseline, zero threshold and hold, spare address ignored
    cfg_write(REG_ALPHA, 32'd0);
    cfg_write(REG_THR, 32'd0);
    cfg_write(REG_HOLD, 32'd0);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    push_sample(-32768, -32768, -32768, 32'd5000);
    push_sample(-32768, -32768, -32768, 32'd5000);
    push_sample(0, 0, 0, 32'd5001);
    push_sample(0, 0, 0, 32'd5001);
    settle();

    // alpha above one saturates; threshold written with junk in the upper half
    cfg_write(REG_ALPHA, 32'hFFFF_FFFF);
    cfg_write(REG_THR, 32'hABCD_FFFF);
    cfg_write(REG_HOLD, 32'd65535);
    push_sample(32767, 0, 0, 32'd6000);
    push_sample(-5, 7, -9, 32'd6001);
    push_sample(100, -200, 300, 32'd6002);
    settle();

    cfg_write(REG_ALPHA, 32'd1);
    cfg_write(REG_THR, 32'd10);
    push_sample(0, 0, 1256, 32'd6100);
    push_sample(3000, -3000, 1256, 32'd6120);
    settle();

    cfg_write(REG_ALPHA, 32'd65536);
    push_sample(0, 0, 1256, 32'd6200);
    push_sample(-20000, 15000, 1256, 32'd6220);
    settle();

    clock_ms = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_ALPHA, $urandom_range(600, 20000));
      cfg_write(REG_THR, $urandom_range(100, 2500));
      cfg_write(REG_HOLD, $urandom_range(0, 600));
      send_idle_pct = send_plan[ph];
      stall_pct = stall_plan[ph];
      for (int n = 0; n < 100; n++) begin
        kind = $urandom_range(99);
        clock_ms += (kind % 31 == 0) ? $urandom : $urandom_range(0, 40);
        if (kind < 75)
          push_sample(int'($urandom_range(400)) - 200, int'($urandom_range(400)) - 200,
                      1256 + int'($urandom_range(400)) - 200, clock_ms);
        else if (kind < 93)
          push_sample($urandom_range(65535), $urandom_range(65535),
                      $urandom_range(65535), clock_ms);
        else
          push_sample($urandom, $urandom, $urandom, $urandom);
      end
      if (ph == 0) begin
        @(posedge clk);
        hold_off_req = 400;
      end
      settle();
    end

    if (mismatches == 0 && expected_readings.size() == 0)
      $display("[impact_detector_ema_hold] OK");
    else
      $display("[impact_detector_ema_hold] ERROR");
    $finish;
  end

endmodule
